[rtl/fcle_pkg.sv]
// Package for the front-coded lexicon encoder.
// Holds the payload structs, the job descriptor passed from front to back and the codes.
// No dependencies.
package fcle_pkg;

    localparam int CNT_W     = 22;
    localparam int LEN_W     = 6;
    localparam int CLEN_W    = 8;
    localparam int BYTE_W    = 8;
    localparam int PFX_W     = 4;
    localparam int JOB_DEPTH = 2;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX          = 22'h3F_FFFF;
    localparam logic [CNT_W-1:0] SIZE_LIMIT_RESET = 22'd3145728;
    localparam logic [PFX_W-1:0] NIB_MAX          = 4'd15;

    localparam logic [1:0] KIND_BODY   = 2'd0;
    localparam logic [1:0] KIND_BUCKET = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_BIG   = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN   = 2'd2;
    localparam logic [1:0] STATUS_BAD_ORDER = 2'd3;

    typedef enum logic [1:0] {
        ORD_EQ,
        ORD_GT,
        ORD_LT
    } ord_t;

    typedef enum logic [1:0] {
        JOB_ERROR,
        JOB_FULL,
        JOB_FRONT
    } job_kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_HEAD,
        B_LEN,
        B_SUF,
        B_BYTES,
        B_STATUS
    } back_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              has_byte;
        logic              word_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       out_kind;
        logic [CNT_W-1:0] out_value;
        logic [1:0]       status;
        logic             run_last;
    } out_item_t;

    typedef struct packed {
        job_kind_t        kind;
        logic [1:0]       status;
        logic             buf_sel;
        logic [LEN_W-1:0] len;
        logic [PFX_W-1:0] pre;
        logic [CNT_W-1:0] offset;
    } job_t;

    typedef struct packed {
        logic             buf_sel;
        logic [LEN_W-1:0] idx;
    } rd_req_t;

endpackage

[rtl/fcle_fifo.sv]
// Small register-based first-in first-out queue of any packed type.
// Used for the job queue and the result queue; depends on nothing else.
module fcle_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  T                           push_data,
    input  logic                       pop,
    output T                           pop_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/fcle_front.sv]
// Front part of the encoder: takes word bytes, keeps the word buffers and the run counters,
// and turns each word end into a job descriptor. Depends on fcle_pkg.
module fcle_front #(
    parameter int BUCKET_WORDS   = 16,
    parameter int MAX_WORD_BYTES = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  fcle_pkg::in_item_t        in_item,
    output logic                      full,
    input  logic                      cfg_we,
    input  logic [fcle_pkg::CNT_W-1:0] cfg_wdata,
    output logic                      job_push,
    output fcle_pkg::job_t            job,
    input  logic                      job_done,
    input  fcle_pkg::rd_req_t         rd_req,
    output logic [fcle_pkg::BYTE_W-1:0] rd_data
);

    import fcle_pkg::*;

    localparam int IW = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;
    localparam int AW = IW + 1;
    localparam int BW = $clog2(BUCKET_WORDS);

    logic [BYTE_W-1:0] mem [2**AW];

    logic [CNT_W-1:0]  size_limit_reg;
    logic              ptr_reg, ptr_next;
    logic [LEN_W-1:0]  prev_length_reg, prev_length_next;
    logic [CLEN_W-1:0] cur_length_reg, cur_length_next;
    logic [PFX_W-1:0]  prefix_reg, prefix_next;
    ord_t              order_reg, order_next;
    logic [31:0]       word_count_reg, word_count_next;
    logic [BW-1:0]     bucket_pos_reg, bucket_pos_next;
    logic [CNT_W-1:0]  bucket_count_reg, bucket_count_next;
    logic [CNT_W-1:0]  body_bytes_reg, body_bytes_next;
    logic [1:0]        outstanding_reg, outstanding_next;
    logic [BYTE_W-1:0] prev_rd_reg;
    logic [BYTE_W-1:0] rd_data_reg;

    logic              accept;
    logic              in_range;
    logic              has_prev;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     pf_addr;
    logic [CLEN_W-1:0] len_upd;
    logic [PFX_W-1:0]  prefix_upd;
    ord_t              order_upd;
    logic [CNT_W+2:0]  total;
    logic              size_bad;
    logic              len_bad;
    logic              order_bad;
    logic              word_ok;
    logic              bucket_start;
    logic [LEN_W-1:0]  len6;
    logic [LEN_W-1:0]  suf6;
    logic              suf_long;
    logic [LEN_W:0]    grow;
    logic [CNT_W:0]    body_sum;

    // Two outstanding jobs mean the older one may still be reading the buffer that
    // the next word would be written into.
    assign full     = (outstanding_reg >= 2'd2);
    assign accept   = push && !full;
    assign rd_data  = rd_data_reg;
    assign job_push = accept && in_item.word_end;

    always_comb
    begin
        in_range = (cur_length_reg < CLEN_W'(MAX_WORD_BYTES));
        has_prev = (cur_length_reg < {2'b00, prev_length_reg});
        wr_en    = accept && in_item.has_byte && in_range;
        wr_addr  = {ptr_reg, cur_length_reg[IW-1:0]};

        order_upd  = order_reg;
        prefix_upd = prefix_reg;
        if (in_item.has_byte && in_range && (order_reg == ORD_EQ))
        begin
            if (has_prev)
            begin
                if (prev_rd_reg < in_item.byte_value)
                begin
                    order_upd = ORD_GT;
                end
                else if (prev_rd_reg > in_item.byte_value)
                begin
                    order_upd = ORD_LT;
                end
                else if (prefix_reg < NIB_MAX)
                begin
                    prefix_upd = prefix_reg + 1'b1;
                end
            end
            else
            begin
                order_upd = ORD_GT;
            end
        end
        len_upd = (in_item.has_byte && (cur_length_reg != '1)) ? cur_length_reg + 1'b1
                                                                : cur_length_reg;

        total     = {1'b0, bucket_count_reg, 2'b00} + {3'b000, body_bytes_reg};
        size_bad  = (total > {3'b000, size_limit_reg});
        len_bad   = (len_upd == '0) || (len_upd > CLEN_W'(MAX_WORD_BYTES));
        order_bad = (order_upd == ORD_LT)
                 || ((order_upd == ORD_EQ) && (len_upd <= {2'b00, prev_length_reg}));
        word_ok   = !size_bad && !len_bad && !order_bad;

        bucket_start = (bucket_pos_reg == '0);
        len6         = len_upd[LEN_W-1:0];
        suf6         = len6 - {2'b00, prefix_upd};
        suf_long     = (suf6 > LEN_W'(NIB_MAX));
        if (bucket_start)
        begin
            grow = {1'b0, len6} + 1'b1;
        end
        else if (suf_long)
        begin
            grow = {1'b0, suf6} + 2'd2;
        end
        else
        begin
            grow = {1'b0, suf6} + 1'b1;
        end
        body_sum = {1'b0, body_bytes_reg} + {{(CNT_W-LEN_W){1'b0}}, grow};

        job.status  = STATUS_OK;
        job.kind    = bucket_start ? JOB_FULL : JOB_FRONT;
        job.buf_sel = ptr_reg;
        job.len     = len6;
        job.pre     = prefix_upd;
        job.offset  = body_bytes_reg;
        priority if (size_bad)
        begin
            job.kind   = JOB_ERROR;
            job.status = STATUS_TOO_BIG;
        end
        else if (len_bad)
        begin
            job.kind   = JOB_ERROR;
            job.status = STATUS_BAD_LEN;
        end
        else if (order_bad)
        begin
            job.kind   = JOB_ERROR;
            job.status = STATUS_BAD_ORDER;
        end

        ptr_next          = ptr_reg;
        prev_length_next  = prev_length_reg;
        cur_length_next   = cur_length_reg;
        prefix_next       = prefix_reg;
        order_next        = order_reg;
        word_count_next   = word_count_reg;
        bucket_pos_next   = bucket_pos_reg;
        bucket_count_next = bucket_count_reg;
        body_bytes_next   = body_bytes_reg;
        if (accept)
        begin
            if (in_item.word_end)
            begin
                cur_length_next = '0;
                prefix_next     = '0;
                order_next      = ORD_EQ;
                if (word_ok)
                begin
                    ptr_next         = !ptr_reg;
                    prev_length_next = len6;
                    word_count_next  = word_count_reg + 1'b1;
                    if (word_count_reg == '1)
                    begin
                        bucket_pos_next = '0;
                    end
                    else if (bucket_pos_reg == BW'(BUCKET_WORDS - 1))
                    begin
                        bucket_pos_next = '0;
                    end
                    else
                    begin
                        bucket_pos_next = bucket_pos_reg + 1'b1;
                    end
                    if (bucket_start && (bucket_count_reg != CNT_MAX))
                    begin
                        bucket_count_next = bucket_count_reg + 1'b1;
                    end
                    body_bytes_next = (body_sum > {1'b0, CNT_MAX}) ? CNT_MAX
                                                                    : body_sum[CNT_W-1:0];
                end
            end
            else
            begin
                cur_length_next = len_upd;
                prefix_next     = prefix_upd;
                order_next      = order_upd;
            end
        end

        unique case ({job_push, job_done})
            2'b10:   outstanding_next = outstanding_reg + 1'b1;
            2'b01:   outstanding_next = outstanding_reg - 1'b1;
            default: outstanding_next = outstanding_reg;
        endcase

        // Look ahead into the previous word at the position of the next byte.
        pf_addr = {!ptr_next, cur_length_next[IW-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_limit_reg   <= SIZE_LIMIT_RESET;
            ptr_reg          <= 1'b0;
            prev_length_reg  <= '0;
            cur_length_reg   <= '0;
            prefix_reg       <= '0;
            order_reg        <= ORD_EQ;
            word_count_reg   <= '0;
            bucket_pos_reg   <= '0;
            bucket_count_reg <= '0;
            body_bytes_reg   <= '0;
            outstanding_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_limit_reg <= cfg_wdata;
            end
            ptr_reg          <= ptr_next;
            prev_length_reg  <= prev_length_next;
            cur_length_reg   <= cur_length_next;
            prefix_reg       <= prefix_next;
            order_reg        <= order_next;
            word_count_reg   <= word_count_next;
            bucket_pos_reg   <= bucket_pos_next;
            bucket_count_reg <= bucket_count_next;
            body_bytes_reg   <= body_bytes_next;
            outstanding_reg  <= outstanding_next;
        end
    end

    // The only overlap of write and look-ahead is a one-byte word ending with its byte.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_item.byte_value;
        end
        prev_rd_reg <= (wr_en && (wr_addr == pf_addr)) ? in_item.byte_value : mem[pf_addr];
        rd_data_reg <= mem[{rd_req.buf_sel, rd_req.idx[IW-1:0]}];
    end

endmodule

[rtl/fcle_back.sv]
// Back part of the encoder: takes job descriptors and emits each word's run of results.
// Reads word bytes through the front's memory port; depends on fcle_pkg.
module fcle_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            job_empty,
    input  fcle_pkg::job_t                  job,
    output logic                            job_pop,
    output logic                            job_done,
    output fcle_pkg::rd_req_t               rd_req,
    input  logic [fcle_pkg::BYTE_W-1:0]     rd_data,
    output logic                            out_push,
    output fcle_pkg::out_item_t             out_data,
    input  logic [fcle_pkg::OUT_CNT_W-1:0]  out_count
);

    import fcle_pkg::*;

    back_state_t      state_reg, state_next;
    job_t             job_reg, job_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             s1_valid_reg;
    out_item_t        s1_item_reg;
    logic             s1_mem_reg;

    logic             space;
    logic             issue;
    logic             from_mem;
    out_item_t        item;
    logic [LEN_W-1:0] suf;
    logic             suf_long;
    logic [LEN_W-1:0] idx_inc;

    always_comb
    begin
        suf      = job_reg.len - {2'b00, job_reg.pre};
        suf_long = (suf > LEN_W'(NIB_MAX));
        idx_inc  = idx_reg + 1'b1;
        // Room for this result and the one already in flight.
        space    = (({1'b0, out_count} + {{OUT_CNT_W{1'b0}}, s1_valid_reg})
                    < (OUT_CNT_W+1)'(OUT_DEPTH));

        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        issue      = 1'b0;
        from_mem   = 1'b0;
        job_pop    = 1'b0;
        job_done   = 1'b0;
        item       = '0;
        item.out_kind = KIND_BODY;
        rd_req.buf_sel = job_reg.buf_sel;
        rd_req.idx     = idx_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop  = 1'b1;
                    job_next = job;
                    unique case (job.kind)
                        JOB_FULL:  state_next = B_HEAD;
                        JOB_FRONT: state_next = B_LEN;
                        default:   state_next = B_STATUS;
                    endcase
                end
            end
            B_HEAD:
            begin
                if (space)
                begin
                    issue          = 1'b1;
                    item.out_kind  = KIND_BUCKET;
                    item.out_value = job_reg.offset;
                    state_next     = B_LEN;
                end
            end
            B_LEN:
            begin
                if (space)
                begin
                    issue = 1'b1;
                    if (job_reg.kind == JOB_FULL)
                    begin
                        item.out_value = {{(CNT_W-LEN_W){1'b0}}, job_reg.len};
                        idx_next       = '0;
                        state_next     = B_BYTES;
                    end
                    else if (suf_long)
                    begin
                        item.out_value = {{(CNT_W-PFX_W){1'b0}}, job_reg.pre};
                        state_next     = B_SUF;
                    end
                    else
                    begin
                        item.out_value = {{(CNT_W-8){1'b0}}, suf[3:0], job_reg.pre};
                        idx_next       = {2'b00, job_reg.pre};
                        state_next     = B_BYTES;
                    end
                end
            end
            B_SUF:
            begin
                if (space)
                begin
                    issue          = 1'b1;
                    item.out_value = {{(CNT_W-LEN_W){1'b0}}, suf};
                    idx_next       = {2'b00, job_reg.pre};
                    state_next     = B_BYTES;
                end
            end
            B_BYTES:
            begin
                if (space)
                begin
                    issue    = 1'b1;
                    from_mem = 1'b1;
                    idx_next = idx_inc;
                    if (idx_inc >= job_reg.len)
                    begin
                        state_next = B_STATUS;
                    end
                end
            end
            B_STATUS:
            begin
                if (space)
                begin
                    issue         = 1'b1;
                    item.out_kind = KIND_STATUS;
                    item.status   = job_reg.status;
                    item.run_last = 1'b1;
                    job_done      = 1'b1;
                    state_next    = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        out_push = s1_valid_reg;
        out_data = s1_item_reg;
        if (s1_mem_reg)
        begin
            out_data.out_value = {{(CNT_W-BYTE_W){1'b0}}, rd_data};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        idx_reg     <= idx_next;
        s1_item_reg <= item;
        s1_mem_reg  <= from_mem;
    end

endmodule

[rtl/front_coded_lexicon_encoder.sv]
// Front-coded lexicon encoder. Input bytes are taken one per cycle while full is low; each
// word end becomes a run that the back pushes into the result queue at one result per
// cycle while the queue has room. Each byte is loaded by the front, then emitted by the back.
// The input stalls while two word runs are still pending in the back.
// Reset (rst_n low, asynchronous) empties both queues, clears all counters and sets the
// size limit to 3145728; the word buffers are not cleared and need no clearing pass.
module front_coded_lexicon_encoder #(
    parameter int BUCKET_WORDS   = 16,
    parameter int MAX_WORD_BYTES = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  fcle_pkg::in_item_t         in_item,
    output logic                       full,
    output logic                       empty,
    input  logic                       pop,
    output fcle_pkg::out_item_t        out_item,
    input  logic                       cfg_we,
    input  logic [fcle_pkg::CNT_W-1:0] cfg_wdata
);

    import fcle_pkg::*;

    // The design splits into a front that loads and checks words and a back that emits.
    // The front holds two word buffers in one memory and swaps them on every word that passes
    // its checks, so the next word can load while the back still reads the last one.
    // A job descriptor per word end carries everything the back needs: the kind of run,
    // the status code, the buffer to read, the length, the shared prefix and the offset.

    job_t              job_in;
    job_t              job_out;
    logic              job_push;
    logic              job_pop;
    logic              job_empty;
    logic              job_done;
    rd_req_t           rd_req;
    logic [BYTE_W-1:0] rd_data;
    logic              res_push;
    out_item_t         res_data;
    logic [OUT_CNT_W-1:0] res_count;
    logic              res_pop;

    fcle_front #(
        .BUCKET_WORDS   (BUCKET_WORDS),
        .MAX_WORD_BYTES (MAX_WORD_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .full      (full),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .job_push  (job_push),
        .job       (job_in),
        .job_done  (job_done),
        .rd_req    (rd_req),
        .rd_data   (rd_data)
    );

    // The front never has more than two jobs outstanding, so this queue cannot overflow.
    fcle_fifo #(
        .T     (job_t),
        .DEPTH (JOB_DEPTH)
    ) u_job_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .pop_data  (job_out),
        .empty     (job_empty),
        .count     ()
    );

    fcle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .job_done  (job_done),
        .rd_req    (rd_req),
        .rd_data   (rd_data),
        .out_push  (res_push),
        .out_data  (res_data),
        .out_count (res_count)
    );

    // The result queue decouples the back from the consumer; the back only issues a
    // result when a slot is free for it, counting the one in flight.
    assign res_pop = pop && !empty;

    fcle_fifo #(
        .T     (out_item_t),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .pop       (res_pop),
        .pop_data  (out_item),
        .empty     (empty),
        .count     (res_count)
    );

endmodule
